/* rtl/rmq_pkg.sv */
package rmq_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int M_W       = 18;
	localparam int N_ENT     = 9;
	localparam int SUM_W     = 21;
	localparam int RAD_W     = 19;
	localparam int D_W       = 19;
	localparam int MAG_W     = D_W;
	localparam int ROOT_W    = 18;
	localparam int SQ_W      = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 2;
	localparam int N_W       = MAG_W + FRAC_BITS - 1;
	localparam int Q_W       = 18;
	localparam int LANES     = 4;

	localparam logic [Q_W-1:0] LIM = Q_W'(ONE);

	localparam logic [1:0] IDX_X = 2'd0;
	localparam logic [1:0] IDX_Y = 2'd1;
	localparam logic [1:0] IDX_Z = 2'd2;
	localparam logic [1:0] IDX_W = 2'd3;

	typedef struct packed {
		logic                        inv;
		logic [1:0]                  ridx;
		logic [RAD_W-1:0]            rad;
		logic [LANES-1:0][D_W-1:0]   d;
	} rmq_item_t;

	typedef struct packed {
		logic                        inv;
		logic [LANES-1:0][Q_W-1:0]   q;
	} rmq_result_t;

endpackage

/* rtl/rmq_front.sv */
module rmq_front import rmq_pkg::*; (
	input  logic [N_ENT-1:0][M_W-1:0] mat,
	output rmq_item_t                 item
);

	logic signed [SUM_W-1:0] a [N_ENT];
	logic signed [D_W-1:0]   e [N_ENT];
	logic signed [SUM_W-1:0] trace;
	logic signed [SUM_W-1:0] rad_s;
	logic [1:0]              axis;
	logic [1:0]              ridx;
	logic [LANES-1:0][D_W-1:0] d;
	logic                    inv;

	always_comb begin
		for (int k = 0; k < N_ENT; k++) begin
			a[k] = SUM_W'($signed(mat[k]));
			e[k] = D_W'($signed(mat[k]));
		end
	end

	assign trace = a[0] + a[4] + a[8];

	always_comb begin
		if ($signed(mat[0]) < $signed(mat[4])) begin
			axis = ($signed(mat[4]) < $signed(mat[8])) ? IDX_Z : IDX_Y;
		end else begin
			axis = ($signed(mat[0]) < $signed(mat[8])) ? IDX_Z : IDX_X;
		end
	end

	always_comb begin
		d     = '0;
		ridx  = IDX_W;
		rad_s = '0;
		if (!trace[SUM_W-1] && trace != '0) begin
			rad_s    = trace + SUM_W'(ONE);
			ridx     = IDX_W;
			d[IDX_X] = e[7] - e[5];
			d[IDX_Y] = e[2] - e[6];
			d[IDX_Z] = e[3] - e[1];
		end else begin
			ridx = axis;
			case (axis)
				IDX_X: begin
					rad_s    = a[0] - a[4] - a[8] + SUM_W'(ONE);
					d[IDX_W] = e[7] - e[5];
					d[IDX_Y] = e[3] + e[1];
					d[IDX_Z] = e[6] + e[2];
				end
				IDX_Y: begin
					rad_s    = a[4] - a[8] - a[0] + SUM_W'(ONE);
					d[IDX_W] = e[2] - e[6];
					d[IDX_Z] = e[7] + e[5];
					d[IDX_X] = e[1] + e[3];
				end
				IDX_Z: begin
					rad_s    = a[8] - a[0] - a[4] + SUM_W'(ONE);
					d[IDX_W] = e[3] - e[1];
					d[IDX_X] = e[2] + e[6];
					d[IDX_Y] = e[5] + e[7];
				end
				default: begin
					rad_s = '0;
				end
			endcase
		end
	end

	assign inv = rad_s[SUM_W-1] || rad_s == '0;

	always_comb begin
		item.inv  = inv;
		item.ridx = ridx;
		item.rad  = inv ? '0 : rad_s[RAD_W-1:0];
		item.d    = d;
	end

endmodule

/* rtl/rmq_queue.sv */
module rmq_queue import rmq_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  rmq_item_t wr_item,
	output logic      rd_valid,
	input  logic      rd_ready,
	output rmq_item_t rd_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rmq_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = count_q != CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

/* rtl/rmq_back.sv */
module rmq_back import rmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  rmq_item_t   in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output rmq_result_t out_result
);

	typedef struct packed {
		logic                      inv;
		logic [1:0]                ridx;
		logic [LANES-1:0][D_W-1:0] d;
		logic [REM_W-1:0]          rem;
		logic [ROOT_W-1:0]         root;
		logic [SQ_W-1:0]           rad;
	} sq_t;

	typedef struct packed {
		logic                         inv;
		logic [1:0]                   ridx;
		logic [ROOT_W-1:0]            root;
		logic [LANES-1:0]             neg;
		logic [LANES-1:0]             ovf;
		logic [LANES-1:0][ROOT_W-1:0] rem;
		logic [LANES-1:0][Q_W-1:0]    nlow;
		logic [LANES-1:0][Q_W-1:0]    quo;
	} dv_t;

	function automatic sq_t sq_step(input sq_t x);
		sq_t              y;
		logic [REM_W+1:0] r2;
		logic [REM_W+1:0] trial;
		y     = x;
		r2    = {x.rem, x.rad[SQ_W-1 -: 2]};
		trial = {2'b00, x.root, 2'b01};
		if (r2 >= trial) begin
			y.rem  = REM_W'(r2 - trial);
			y.root = {x.root[ROOT_W-2:0], 1'b1};
		end else begin
			y.rem  = REM_W'(r2);
			y.root = {x.root[ROOT_W-2:0], 1'b0};
		end
		y.rad = {x.rad[SQ_W-3:0], 2'b00};
		return y;
	endfunction

	function automatic dv_t dv_prep(input sq_t x);
		dv_t                  y;
		logic [MAG_W-1:0]     mag;
		logic [N_W-1:0]       n;
		logic [N_W-Q_W-1:0]   hi;
		y      = '0;
		y.inv  = x.inv;
		y.ridx = x.ridx;
		y.root = x.root;
		for (int l = 0; l < LANES; l++) begin
			y.neg[l]  = x.d[l][D_W-1];
			mag       = y.neg[l] ? (~x.d[l] + D_W'(1)) : x.d[l];
			n         = {mag, {(FRAC_BITS-1){1'b0}}} + N_W'(x.root >> 1);
			hi        = n[N_W-1:Q_W];
			y.ovf[l]  = ROOT_W'(hi) >= x.root;
			y.rem[l]  = ROOT_W'(hi);
			y.nlow[l] = n[Q_W-1:0];
		end
		return y;
	endfunction

	function automatic dv_t dv_step(input dv_t x);
		dv_t             y;
		logic [ROOT_W:0] r2;
		logic            b;
		y = x;
		for (int l = 0; l < LANES; l++) begin
			r2 = {x.rem[l], x.nlow[l][Q_W-1]};
			b  = r2 >= {1'b0, x.root};
			y.rem[l]  = b ? ROOT_W'(r2 - {1'b0, x.root}) : ROOT_W'(r2);
			y.nlow[l] = {x.nlow[l][Q_W-2:0], 1'b0};
			y.quo[l]  = {x.quo[l][Q_W-2:0], b};
		end
		return y;
	endfunction

	function automatic rmq_result_t res_make(input dv_t x);
		rmq_result_t     r;
		logic [ROOT_W:0] h;
		logic [Q_W-1:0]  mag;
		r.inv = x.inv;
		h     = ({1'b0, x.root} + (ROOT_W+1)'(1)) >> 1;
		for (int l = 0; l < LANES; l++) begin
			if (2'(l) == x.ridx) begin
				mag    = (h > (ROOT_W+1)'(LIM)) ? LIM : h[Q_W-1:0];
				r.q[l] = mag;
			end else begin
				mag    = (x.ovf[l] || x.quo[l] > LIM) ? LIM : x.quo[l];
				r.q[l] = x.neg[l] ? (~mag + Q_W'(1)) : mag;
			end
			if (x.inv) begin
				r.q[l] = '0;
			end
		end
		return r;
	endfunction

	logic              adv;
	logic [ROOT_W:0]   sq_v_s;
	sq_t               sq_s [ROOT_W+1];
	logic [Q_W:0]      dv_v_s;
	dv_t               dv_s [Q_W+1];
	logic              out_valid_q;
	rmq_result_t       res_q;
	sq_t               sq_in;

	assign adv        = !out_valid_q || out_ready;
	assign in_ready   = adv;
	assign out_valid  = out_valid_q;
	assign out_result = res_q;

	always_comb begin
		sq_in      = '0;
		sq_in.inv  = in_item.inv;
		sq_in.ridx = in_item.ridx;
		sq_in.d    = in_item.d;
		sq_in.rad  = SQ_W'({in_item.rad, {FRAC_BITS{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s      <= '0;
			dv_v_s      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			sq_v_s      <= {sq_v_s[ROOT_W-1:0], in_valid};
			dv_v_s      <= {dv_v_s[Q_W-1:0], sq_v_s[ROOT_W]};
			out_valid_q <= dv_v_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0] <= sq_in;
			dv_s[0] <= dv_prep(sq_s[ROOT_W]);
			res_q   <= res_make(dv_s[Q_W]);
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= sq_step(sq_s[k]);
			end
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_dv
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1] <= dv_step(dv_s[k]);
			end
		end
	end

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Channel  Dir  tdata                                        tuser
// s_*      in   m00 m01 m02 m10 m11 m12 m20 m21 m22, 18 b ea -
// m_*      out  qx qy qz qw, 18 b each                       invalid
//
// Takes one word per cycle while s_tready is high.
// The back end is built around the 18-stage square root and the 18-stage divider pipelines.
// arst_n clears the queue and all stage valid bits.
// A stall on m_tready freezes the back pipeline; the front keeps filling the queue
// and drops s_tready only when it holds QUEUE_DEPTH words.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,  // qx qy qz qw
	output logic [0:0]   m_tuser   // invalid
);

	logic [N_ENT-1:0][M_W-1:0] mat;
	rmq_item_t                 f_item;
	rmq_item_t                 q_item;
	logic                      q_valid;
	logic                      q_ready;
	rmq_result_t               result;

	assign mat = s_tdata[N_ENT*M_W-1:0];

	rmq_front u_front (
		.mat  (mat),
		.item (f_item)
	);

	rmq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_tvalid),
		.wr_ready (s_tready),
		.wr_item  (f_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	rmq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_item    (q_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata    = result.q;
	assign m_tuser[0] = result.inv;

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("invalid word carries nonzero components");

	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> q_valid)
		else $error("queue empty after a push");

	a_lim_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[17:0]) <= $signed(LIM) &&
		$signed(m_tdata[17:0]) >= -$signed(LIM))
		else $error("qx beyond limit");

	a_lim_w: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[71:54]) <= $signed(LIM) &&
		$signed(m_tdata[71:54]) >= -$signed(LIM))
		else $error("qw beyond limit");

endmodule
